>>> sv/acrt_pkg.sv
// Package for the aging replacement cache directory.
// Holds item and result types, command codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
`timescale 1ns / 1ps

package acrt_pkg;

    localparam int CACHE_SLOTS = 16;
    localparam int IDX_W       = $clog2(CACHE_SLOTS);
    localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;

    localparam logic [31:0] AGE_FULL = 32'hffff_ffff;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic        hint_valid;
        logic [3:0]  hint_slot;
        logic [7:0]  pack_index;
        logic [23:0] elem_index;
        logic [30:0] elem_size;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [7:0]  found_pack;
        logic [23:0] found_elem;
        logic [30:0] found_size;
        logic        evicted;
        logic [31:0] evicted_id;
        logic [4:0]  removed_count;
        logic [4:0]  entry_count;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  pack;
        logic [23:0] elem;
        logic [30:0] size;
        logic [31:0] age;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_HINT_RD,
        ST_HINT_CHK,
        ST_LOOKUP,
        ST_AGE,
        ST_REPLACE,
        ST_INSERT,
        ST_REMOVE,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the request, clear scan state and result
        logic hint_rd;   // read the hint slot
        logic issue;     // read at the scan pointer and advance it
        logic lk_hit;    // returned entry matched: refresh its age, record it
        logic age_step;  // returned entry: decrement age, track least age
        logic rm_step;   // returned entry: drop it or compact it down
        logic rm_end;    // commit compacted count and removed count
        logic ins_new;   // write new entry into the next free slot
        logic ins_repl;  // overwrite the least-aged entry
        logic out_load;  // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       hint_ok;
        logic       full;
        logic       pipe_valid;
        logic       match;
        logic       scan_more;
        logic       age_last;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> sv/acrt_if.sv
// Request and response channel interfaces for the cache directory.
// Depends on acrt_pkg for the payload types.
`timescale 1ns / 1ps

interface acrt_req_if;
    logic                valid;
    logic                ready;
    acrt_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface acrt_rsp_if;
    logic                valid;
    logic                ready;
    acrt_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/acrt_ctrl.sv
// Command sequencer for the cache directory.
// Depends on acrt_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
`timescale 1ns / 1ps

module acrt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  acrt_pkg::dp_stat_t stat,
    output acrt_pkg::dp_cmd_t  cmd
);
    import acrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_LOOKUP: state_next = stat.hint_ok ? ST_HINT_RD : ST_LOOKUP;
                    CMD_INSERT: state_next = stat.full ? ST_AGE : ST_INSERT;
                    CMD_REMOVE: state_next = ST_REMOVE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_HINT_RD:
            begin
                cmd.hint_rd = 1'b1;
                state_next  = ST_HINT_CHK;
            end
            ST_HINT_CHK:
            begin
                if (stat.match)
                begin
                    cmd.lk_hit = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (stat.pipe_valid && stat.match)
                begin
                    cmd.lk_hit = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!stat.pipe_valid)
                begin
                    // scan exhausted: miss, result stays zero
                    state_next = ST_DONE;
                end
            end
            ST_AGE:
            begin
                cmd.issue    = stat.scan_more;
                cmd.age_step = stat.pipe_valid;
                if (stat.pipe_valid && stat.age_last)
                begin
                    state_next = ST_REPLACE;
                end
            end
            ST_REPLACE:
            begin
                cmd.ins_repl = 1'b1;
                state_next   = ST_DONE;
            end
            ST_INSERT:
            begin
                cmd.ins_new = 1'b1;
                state_next  = ST_DONE;
            end
            ST_REMOVE:
            begin
                cmd.issue   = stat.scan_more;
                cmd.rm_step = stat.pipe_valid;
                if (!stat.scan_more && !stat.pipe_valid)
                begin
                    cmd.rm_end = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/acrt_datapath.sv
// Entry memory, scan pointers, least-age tracking and result registers.
// Depends on acrt_pkg; steered by acrt_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module acrt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  acrt_pkg::req_item_t in_data,
    input  acrt_pkg::dp_cmd_t   cmd,
    output acrt_pkg::dp_stat_t  stat,
    output logic                out_valid,
    output acrt_pkg::rsp_item_t out_data,
    input  logic                out_ready
);
    import acrt_pkg::*;

    entry_t entry_mem [CACHE_SLOTS];

    req_item_t        item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic [CNT_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] wr_ptr_next;
    logic             pipe_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic [31:0]      min_age_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic [31:0]      min_id_reg;
    rsp_item_t        res_reg;
    rsp_item_t        res_next;
    logic             out_valid_reg;
    rsp_item_t        out_reg;
    rsp_item_t        out_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [31:0]      dec_age;
    logic             min_take;
    entry_t           new_entry;

    assign dec_age  = rd_data_reg.age - {31'd0, (rd_data_reg.age != 32'd0)};
    assign min_take = (rd_idx_reg == '0) || (dec_age < min_age_reg);

    assign new_entry = '{id:   item_reg.id,
                         pack: item_reg.pack_index,
                         elem: item_reg.elem_index,
                         size: item_reg.elem_size,
                         age:  AGE_FULL};

    assign stat.cmd        = item_reg.cmd;
    assign stat.hint_ok    = item_reg.hint_valid
                             && (32'(item_reg.hint_slot) < 32'(count_reg));
    assign stat.full       = (32'(count_reg) >= CACHE_SLOTS);
    assign stat.pipe_valid = pipe_valid_reg;
    assign stat.match      = (rd_data_reg.id == item_reg.id);
    assign stat.scan_more  = (scan_reg < count_reg);
    assign stat.age_last   = (rd_idx_reg == IDX_W'(CACHE_SLOTS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign rd_en   = cmd.hint_rd || cmd.issue;
    assign rd_addr = cmd.hint_rd ? IDX_W'(item_reg.hint_slot) : scan_reg[IDX_W-1:0];

    // write port select
    always_comb
    begin
        we      = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_data_reg;
        if (cmd.lk_hit)
        begin
            we          = 1'b1;
            wr_data.age = AGE_FULL;
        end
        else if (cmd.age_step)
        begin
            we          = 1'b1;
            wr_data.age = dec_age;
        end
        else if (cmd.rm_step)
        begin
            we      = (rd_data_reg.pack != item_reg.pack_index);
            wr_addr = wr_ptr_reg[IDX_W-1:0];
        end
        else if (cmd.ins_new)
        begin
            we      = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = new_entry;
        end
        else if (cmd.ins_repl)
        begin
            we      = 1'b1;
            wr_addr = min_idx_reg;
            wr_data = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        scan_next   = scan_reg;
        wr_ptr_next = wr_ptr_reg;
        res_next    = res_reg;
        if (cmd.load)
        begin
            scan_next   = '0;
            wr_ptr_next = '0;
            res_next    = '0;
        end
        if (cmd.issue)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.lk_hit)
        begin
            res_next.hit        = 1'b1;
            res_next.slot       = SLOT_W'(rd_idx_reg);
            res_next.found_pack = rd_data_reg.pack;
            res_next.found_elem = rd_data_reg.elem;
            res_next.found_size = rd_data_reg.size;
        end
        if (cmd.rm_step && (rd_data_reg.pack != item_reg.pack_index))
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd.rm_end)
        begin
            count_next             = wr_ptr_reg;
            res_next.removed_count = COUNT_W'(count_reg - wr_ptr_reg);
        end
        if (cmd.ins_new || cmd.ins_repl)
        begin
            res_next.hit        = 1'b1;
            res_next.slot       = cmd.ins_new ? SLOT_W'(count_reg) : SLOT_W'(min_idx_reg);
            res_next.found_pack = item_reg.pack_index;
            res_next.found_elem = item_reg.elem_index;
            res_next.found_size = item_reg.elem_size;
        end
        if (cmd.ins_new)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.ins_repl)
        begin
            res_next.evicted    = 1'b1;
            res_next.evicted_id = min_id_reg;
        end
    end

    // result with the current entry count filled in
    always_comb
    begin
        out_next             = res_reg;
        out_next.entry_count = COUNT_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_reg       <= '0;
            wr_ptr_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            wr_ptr_reg     <= wr_ptr_next;
            pipe_valid_reg <= rd_en;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        res_reg <= res_next;
        if (cmd.age_step && min_take)
        begin
            min_age_reg <= dec_age;
            min_idx_reg <= rd_idx_reg;
            min_id_reg  <= rd_data_reg.id;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> sv/aging_replacement_cache_table.sv
// Top level of the aging replacement cache directory.
// Depends on acrt_pkg, acrt_if, acrt_ctrl and acrt_datapath.
//
//   channel | dir | payload     | handshake
//   --------+-----+-------------+------------------------------
//   req     | in  | req_item_t  | valid/ready, taken when both high
//   rsp     | out | rsp_item_t  | valid/ready, one per request
//
// One request is in work at a time. Entries are scanned one per cycle out of
// a single-port-read memory with a registered read; a failed hint falls back
// to the scan. Reset clears the entry count and control state but not the
// entries; there is no clearing pass. A stalled response holds in the output
// register; the next request is taken and worked while it waits, and only its
// result waits behind it.
`timescale 1ns / 1ps

module aging_replacement_cache_table (
    input logic        clk,
    input logic        rst_n,
    acrt_req_if.sink   req,
    acrt_rsp_if.source rsp
);
    import acrt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    acrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    acrt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (rsp.valid),
        .out_data  (rsp.data),
        .out_ready (rsp.ready)
    );

endmodule

>>> sv/acrt_checker.sv
// Port-level checks for the cache directory, bound onto the top level.
// Depends on acrt_pkg for the payload types and slot count.
`timescale 1ns / 1ps

module acrt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input acrt_pkg::rsp_item_t rsp_data
);
    import acrt_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response dropped or changed while stalled");

    // one request in work: no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_data.entry_count) <= CACHE_SLOTS)
        else $error("entry count beyond slot count");

    // eviction only happens on a full directory insert
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.evicted |->
            rsp_data.hit && (32'(rsp_data.entry_count) == CACHE_SLOTS)
            && (rsp_data.removed_count == '0))
        else $error("eviction reported without a full insert");

    a_remove_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.removed_count != '0) |->
            !rsp_data.hit && !rsp_data.evicted
            && (32'(rsp_data.removed_count) + 32'(rsp_data.entry_count) <= CACHE_SLOTS))
        else $error("remove response carries lookup or insert fields");

endmodule

bind aging_replacement_cache_table acrt_checker u_acrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

>>> dv/aging_replacement_cache_table_tb.sv
// Self-checking testbench for aging_replacement_cache_table.
// Drives directed and random directory commands, predicts each response and
// compares field by field. Depends on acrt_pkg and acrt_if from the RTL.
`timescale 1ns / 1ps

module aging_replacement_cache_table_tb;
    import acrt_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;  // unused command code
    localparam int ID_POOL_SIZE = 24;
    localparam int RANDOM_ITEMS = 430;       // per idling phase
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        req_item_t req;
        int        reps;
        bit        typed;
        rsp_item_t rsp;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    acrt_req_if req_ch ();
    acrt_rsp_if rsp_ch ();

    aging_replacement_cache_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Directory shadow.
    logic [31:0] dir_id   [CACHE_SLOTS];
    logic [7:0]  dir_pack [CACHE_SLOTS];
    logic [23:0] dir_elem [CACHE_SLOTS];
    logic [30:0] dir_size [CACHE_SLOTS];
    logic [31:0] dir_age  [CACHE_SLOTS];
    int          dir_count = 0;

    rsp_item_t   dir_results_due[$];
    logic [31:0] id_pool[ID_POOL_SIZE];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_item_t cache_apply(req_item_t r);
        rsp_item_t o;
        int        k;
        int        w;
        int        gone;
        bit        found;
        o = '0;
        k = 0;
        w = 0;
        gone = 0;
        found = 1'b0;
        case (r.cmd)
            CMD_LOOKUP:
            begin
                if (r.hint_valid && int'(r.hint_slot) < dir_count
                    && dir_id[r.hint_slot] == r.id)
                begin
                    found = 1'b1;
                    k = int'(r.hint_slot);
                end
                else
                begin
                    for (int i = 0; i < dir_count; i++)
                    begin
                        if (dir_id[i] == r.id)
                        begin
                            found = 1'b1;
                            k = i;
                            break;
                        end
                    end
                end
                if (found)
                begin
                    dir_age[k] = AGE_FULL;
                    o.hit = 1'b1;
                    o.slot = 4'(k);
                    o.found_pack = dir_pack[k];
                    o.found_elem = dir_elem[k];
                    o.found_size = dir_size[k];
                end
            end
            CMD_INSERT:
            begin
                if (dir_count < CACHE_SLOTS)
                begin
                    k = dir_count;
                    dir_count++;
                end
                else
                begin
                    // age everything, then take the first least-aged entry
                    for (int i = 0; i < CACHE_SLOTS; i++)
                    begin
                        if (dir_age[i] != 0)
                            dir_age[i] = dir_age[i] - 1;
                        if (dir_age[i] < dir_age[k])
                            k = i;
                    end
                    o.evicted = 1'b1;
                    o.evicted_id = dir_id[k];
                end
                dir_id[k] = r.id;
                dir_pack[k] = r.pack_index;
                dir_elem[k] = r.elem_index;
                dir_size[k] = r.elem_size;
                dir_age[k] = AGE_FULL;
                o.hit = 1'b1;
                o.slot = 4'(k);
                o.found_pack = r.pack_index;
                o.found_elem = r.elem_index;
                o.found_size = r.elem_size;
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < dir_count; i++)
                begin
                    if (dir_pack[i] == r.pack_index)
                        gone++;
                    else
                    begin
                        dir_id[w] = dir_id[i];
                        dir_pack[w] = dir_pack[i];
                        dir_elem[w] = dir_elem[i];
                        dir_size[w] = dir_size[i];
                        dir_age[w] = dir_age[i];
                        w++;
                    end
                end
                dir_count = w;
                o.removed_count = 5'(gone);
            end
            default: ;
        endcase
        o.entry_count = 5'(dir_count);
        return o;
    endfunction

    function automatic req_item_t cmd_item(logic [1:0] cmd, logic [31:0] id, logic hv,
                                           logic [3:0] hs, logic [7:0] pack,
                                           logic [23:0] elem, logic [30:0] size);
        req_item_t r;
        r.cmd = cmd;
        r.id = id;
        r.hint_valid = hv;
        r.hint_slot = hs;
        r.pack_index = pack;
        r.elem_index = elem;
        r.elem_size = size;
        return r;
    endfunction

    // Mostly ids and packs from small pools so lookups hit and removes bite.
    function automatic req_item_t make_request();
        req_item_t r;
        int        roll;
        roll = $urandom_range(99);
        if (roll < 45)
            r.cmd = CMD_LOOKUP;
        else if (roll < 80)
            r.cmd = CMD_INSERT;
        else if (roll < 93)
            r.cmd = CMD_REMOVE;
        else
            r.cmd = CMD_NONE;
        r.id = ($urandom_range(99) < 88) ? id_pool[$urandom_range(ID_POOL_SIZE - 1)]
                                         : $urandom;
        r.hint_valid = 1'($urandom_range(1));
        r.hint_slot = 4'($urandom_range(15));
        if ($urandom_range(99) < 70)
        begin
            // point the hint at the live copy of the id, if there is one
            for (int j = 0; j < dir_count; j++)
            begin
                if (dir_id[j] == r.id)
                    r.hint_slot = 4'(j);
            end
        end
        r.pack_index = ($urandom_range(99) < 85) ? 8'($urandom_range(5))
                                                 : 8'($urandom_range(255));
        r.elem_index = 24'($urandom);
        r.elem_size = 31'($urandom);
        return r;
    endfunction

    task automatic push_request(req_item_t r, bit typed, rsp_item_t want);
        rsp_item_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = r;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = cache_apply(r);
        dir_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (dir_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(int n);
        repeat (n)
            push_request(make_request(), 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        rsp_item_t got;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got = rsp_ch.data;
            if (dir_results_due.size() == 0)
            begin
                $error("response with nothing outstanding: %h", got);
                mismatches++;
            end
            else
            begin
                want = dir_results_due.pop_front();
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("slot", 32'(want.slot), 32'(got.slot));
                check_field("found_pack", 32'(want.found_pack), 32'(got.found_pack));
                check_field("found_elem", 32'(want.found_elem), 32'(got.found_elem));
                check_field("found_size", 32'(want.found_size), 32'(got.found_size));
                check_field("evicted", 32'(want.evicted), 32'(got.evicted));
                check_field("evicted_id", want.evicted_id, got.evicted_id);
                check_field("removed_count", 32'(want.removed_count),
                            32'(got.removed_count));
                check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            end
        end
    end

    // Response side: random back-pressure, or a long hold when asked.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        foreach (id_pool[i])
            id_pool[i] = $urandom;

        // hit/miss on empty, all-ones and all-zeros entries, hint cases,
        // fill, eviction, unused command and compaction
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'd0, 1'b0, 4'd0, 8'd0, 24'd0, 31'd0), 1,
                         1'b1, '0});
        plan.push_back('{cmd_item(CMD_REMOVE, 32'd0, 1'b0, 4'd0, 8'd0, 24'd0, 31'd0), 1,
                         1'b1, '0});
        plan.push_back('{cmd_item(CMD_NONE, '1, 1'b1, '1, '1, '1, '1), 1, 1'b1, '0});
        plan.push_back('{cmd_item(CMD_INSERT, '1, 1'b1, '1, '1, '1, '1), 1, 1'b1,
                         '{hit: 1'b1, found_pack: 8'hff, found_elem: 24'hff_ffff,
                           found_size: 31'h7fff_ffff, entry_count: 5'd1, default: '0}});
        plan.push_back('{cmd_item(CMD_INSERT, 32'd0, 1'b0, 4'd0, 8'd0, 24'd0, 31'd0), 1,
                         1'b1, '{hit: 1'b1, slot: 4'd1, entry_count: 5'd2, default: '0}});
        plan.push_back('{cmd_item(CMD_LOOKUP, '1, 1'b1, 4'd1, 8'd0, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'd0, 1'b1, 4'd1, 8'd0, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'd0, 1'b1, 4'd15, 8'd0, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'd0, 1'b0, 4'd0, 8'd0, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'h1234_5678, 1'b1, 4'd0, 8'd0, 24'd0,
                                  31'd0), 1, 1'b1, '{entry_count: 5'd2, default: '0}});
        plan.push_back('{cmd_item(CMD_INSERT, 32'h100, 1'b0, 4'd0, 8'd3, 24'h10,
                                  31'h55), 14, 1'b0, '0});
        plan.push_back('{cmd_item(CMD_INSERT, 32'hdead_0001, 1'b0, 4'd0, 8'd7, 24'h5a5a5a,
                                  31'h2aaa_aaaa), 1, 1'b0, '0});
        plan.push_back('{cmd_item(CMD_INSERT, 32'hdead_0002, 1'b0, 4'd0, 8'd7, 24'ha5a5a5,
                                  31'h5555_5555), 1, 1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'h105, 1'b1, 4'd7, 8'd0, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_INSERT, 32'hdead_0003, 1'b0, 4'd0, 8'd7, 24'd1,
                                  31'd1), 2, 1'b0, '0});
        plan.push_back('{cmd_item(CMD_NONE, 32'd0, 1'b0, 4'd0, 8'd3, 24'd0, 31'd0), 1,
                         1'b1, '{entry_count: 5'd16, default: '0}});
        plan.push_back('{cmd_item(CMD_REMOVE, 32'd0, 1'b0, 4'd0, 8'd3, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_REMOVE, 32'd0, 1'b0, 4'd0, 8'hff, 24'd0, 31'd0), 1,
                         1'b0, '0});
        plan.push_back('{cmd_item(CMD_LOOKUP, 32'hdead_0002, 1'b1, 4'd0, 8'd0, 24'd0,
                                  31'd0), 1, 1'b0, '0});
        plan.push_back('{cmd_item(CMD_REMOVE, 32'd0, 1'b0, 4'd0, 8'd7, 24'd0, 31'd0), 1,
                         1'b0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 7;
        snk_idle_pct = 57;
        foreach (plan[p])
        begin
            for (int j = 0; j < plan[p].reps; j++)
            begin
                req_item_t r;
                r = plan[p].req;
                r.id = r.id + 32'(j);
                r.elem_index = r.elem_index + 24'(j);
                push_request(r, plan[p].typed, plan[p].rsp);
            end
        end
        run_random(RANDOM_ITEMS);

        // stall the response side and keep offering so the input backs up
        hold_left = HOLD_CYCLES;
        run_random(12);
        drain_results();

        src_idle_pct = 57;
        snk_idle_pct = 7;
        run_random(RANDOM_ITEMS);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(RANDOM_ITEMS);

        drain_results();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
sv/acrt_pkg.sv
sv/acrt_if.sv
sv/acrt_ctrl.sv
sv/acrt_datapath.sv
sv/aging_replacement_cache_table.sv
sv/acrt_checker.sv
dv/aging_replacement_cache_table_tb.sv
